>>> design/tekd_pkg.sv
// ----------------------------------------------------------------------------
// tekd_pkg
// Shared types, codes and helpers for the terminal escape key decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package tekd_pkg;

    typedef struct packed {
        logic       is_end;
        logic [7:0] data_byte;
    } t_in;

    typedef struct packed {
        logic [1:0] result_kind;
        logic [4:0] key_code;
        logic [7:0] char_code;
        logic [2:0] modifiers;
    } t_out;

    typedef struct packed {
        logic valid;
        t_out item;
    } t_res;

    localparam logic [1:0] KIND_KEY  = 2'd0;
    localparam logic [1:0] KIND_CHAR = 2'd1;
    localparam logic [1:0] KIND_NONE = 2'd2;

    localparam logic [4:0] KC_UP     = 5'd0;
    localparam logic [4:0] KC_DOWN   = 5'd1;
    localparam logic [4:0] KC_RIGHT  = 5'd2;
    localparam logic [4:0] KC_LEFT   = 5'd3;
    localparam logic [4:0] KC_SRIGHT = 5'd4;
    localparam logic [4:0] KC_SLEFT  = 5'd5;
    localparam logic [4:0] KC_HOME   = 5'd6;
    localparam logic [4:0] KC_END    = 5'd7;
    localparam logic [4:0] KC_BTAB   = 5'd8;
    localparam logic [4:0] KC_INS    = 5'd9;
    localparam logic [4:0] KC_DEL    = 5'd10;
    localparam logic [4:0] KC_PGUP   = 5'd11;
    localparam logic [4:0] KC_PGDN   = 5'd12;
    localparam logic [4:0] KC_F1     = 5'd13;
    localparam logic [4:0] KC_F5     = 5'd17;
    localparam logic [4:0] KC_F6     = 5'd18;
    localparam logic [4:0] KC_F7     = 5'd19;
    localparam logic [4:0] KC_F8     = 5'd20;
    localparam logic [4:0] KC_F9     = 5'd21;
    localparam logic [4:0] KC_F10    = 5'd22;
    localparam logic [4:0] KC_F11    = 5'd23;
    localparam logic [4:0] KC_F12    = 5'd24;
    localparam logic [4:0] KC_KPENT  = 5'd25;
    localparam logic [4:0] KC_LAST   = KC_KPENT;

    localparam logic [2:0] MOD_NONE  = 3'd0;
    localparam logic [2:0] MOD_ALT   = 3'd2;

    localparam logic [7:0] ESC_BYTE  = 8'h1b;
    localparam logic [19:0] PARAM_CAP = 20'd100000;

    // build a result, zeroing the fields that the kind does not use
    function automatic t_out mk_out(input logic [1:0] kind, input logic [4:0] key,
                                    input logic [7:0] ch, input logic [2:0] mods);
        t_out r;
        r.result_kind = kind;
        r.key_code    = (kind == KIND_KEY)  ? key  : 5'd0;
        r.char_code   = (kind == KIND_CHAR) ? ch   : 8'd0;
        r.modifiers   = (kind == KIND_NONE) ? MOD_NONE : mods;
        return r;
    endfunction

endpackage

`default_nettype wire

>>> design/tekd_in_stage.sv
// ----------------------------------------------------------------------------
// tekd_in_stage
// Input register: holds one byte transaction until the parser takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module tekd_in_stage
    import tekd_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_valid,
    input  t_in  i_data,
    output logic o_stall,
    input  wire  i_take,
    output logic o_valid,
    output t_in  o_data
);

    logic r_valid;
    t_in  r_data;
    logic accept;

    assign o_stall = r_valid && !i_take;
    assign accept  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_data <= i_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

>>> design/tekd_parser.sv
// ----------------------------------------------------------------------------
// tekd_parser
// Sequence state and single-pass decode of one byte or end marker.
// ----------------------------------------------------------------------------
`default_nettype none

module tekd_parser
    import tekd_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_fire,
    input  t_in  i_item,
    output t_res o_res
);

    localparam logic [2:0] PH_IDLE      = 3'd0;
    localparam logic [2:0] PH_ESC       = 3'd1;
    localparam logic [2:0] PH_ALT       = 3'd2;
    localparam logic [2:0] PH_CSI_FIRST = 3'd3;
    localparam logic [2:0] PH_CSI       = 3'd4;
    localparam logic [2:0] PH_SS3_FIRST = 3'd5;
    localparam logic [2:0] PH_SS3       = 3'd6;
    localparam logic [2:0] PH_DRAIN     = 3'd7;

    logic [2:0]  r_phase,   n_phase;
    logic [19:0] r_fp,      n_fp;
    logic [19:0] r_sp,      n_sp;
    logic [1:0]  r_cnt,     n_cnt;
    logic        r_dseen,   n_dseen;
    logic [7:0]  r_alt,     n_alt;

    function automatic logic [5:0] letter_key(input logic [7:0] f, input logic shift);
        logic [5:0] k;
        case (f)
            "A":     k = {1'b1, KC_UP};
            "B":     k = {1'b1, KC_DOWN};
            "C":     k = {1'b1, shift ? KC_SRIGHT : KC_RIGHT};
            "D":     k = {1'b1, shift ? KC_SLEFT : KC_LEFT};
            "H":     k = {1'b1, KC_HOME};
            "F":     k = {1'b1, KC_END};
            "Z":     k = {1'b1, KC_BTAB};
            default: k = 6'd0;
        endcase
        return k;
    endfunction

    function automatic logic [5:0] tilde_key(input logic [19:0] n);
        logic [5:0] k;
        case (n)
            20'd1, 20'd7: k = {1'b1, KC_HOME};
            20'd2:        k = {1'b1, KC_INS};
            20'd3:        k = {1'b1, KC_DEL};
            20'd4, 20'd8: k = {1'b1, KC_END};
            20'd5:        k = {1'b1, KC_PGUP};
            20'd6:        k = {1'b1, KC_PGDN};
            20'd15:       k = {1'b1, KC_F5};
            20'd17:       k = {1'b1, KC_F6};
            20'd18:       k = {1'b1, KC_F7};
            20'd19:       k = {1'b1, KC_F8};
            20'd20:       k = {1'b1, KC_F9};
            20'd21:       k = {1'b1, KC_F10};
            20'd23:       k = {1'b1, KC_F11};
            20'd24:       k = {1'b1, KC_F12};
            default:      k = 6'd0;
        endcase
        return k;
    endfunction

    // keypad application-mode finals; zero means not a keypad byte
    function automatic logic [7:0] keypad_byte(input logic [7:0] f);
        logic [7:0] b;
        case (f)
            "j":     b = "*";
            "k":     b = "+";
            "l":     b = ",";
            "m":     b = "-";
            "n":     b = ".";
            "o":     b = "/";
            "X":     b = "=";
            default: b = (f >= "p" && f <= "y") ? (f - 8'h40) : 8'd0;
        endcase
        return b;
    endfunction

    logic [7:0]  c;
    logic        is_end;
    logic        is_ss3;
    logic        is_digit;
    logic        is_pqrs;
    logic [3:0]  digit;
    logic [19:0] fp_times10;
    logic [19:0] sp_times10;
    logic [1:0]  cnt_f;
    logic [2:0]  mods;
    logic [5:0]  lk;
    logic [5:0]  tk;
    logic [7:0]  kp;
    logic [4:0]  fkey;
    t_res        res;

    always_comb begin
        c          = i_item.data_byte;
        is_end     = i_item.is_end;
        is_ss3     = (r_phase == PH_SS3_FIRST) || (r_phase == PH_SS3);
        is_digit   = (c >= "0") && (c <= "9");
        is_pqrs    = (c >= "P") && (c <= "S");
        digit      = c[3:0];
        fp_times10 = {r_fp[16:0], 3'b000} + {r_fp[18:0], 1'b0} + {16'd0, digit};
        sp_times10 = {r_sp[16:0], 3'b000} + {r_sp[18:0], 1'b0} + {16'd0, digit};
        fkey       = KC_F1 + {3'd0, c[1:0]};

        cnt_f = r_cnt;
        if ((r_dseen || r_cnt != 2'd0) && r_cnt != 2'd3) begin
            cnt_f = r_cnt + 2'd1;
        end
        if (is_ss3) begin
            case (cnt_f)
                2'd0:    mods = MOD_NONE;
                2'd1:    mods = r_fp[2:0] - 3'd1;
                default: mods = r_sp[2:0] - 3'd1;
            endcase
        end else begin
            mods = cnt_f[1] ? (r_sp[2:0] - 3'd1) : MOD_NONE;
        end
        lk = letter_key(c, mods[0]);
        tk = tilde_key(r_fp);
        kp = keypad_byte(c);

        n_phase = r_phase;
        n_fp    = r_fp;
        n_sp    = r_sp;
        n_cnt   = r_cnt;
        n_dseen = r_dseen;
        n_alt   = r_alt;
        res.valid = 1'b0;
        res.item  = mk_out(KIND_NONE, KC_UP, 8'd0, MOD_NONE);

        case (r_phase)
            PH_IDLE: begin
                if (!is_end) begin
                    if (c == ESC_BYTE) begin
                        n_fp    = 20'd0;
                        n_sp    = 20'd0;
                        n_cnt   = 2'd0;
                        n_dseen = 1'b0;
                        n_phase = PH_ESC;
                    end else begin
                        res.valid = 1'b1;
                        res.item  = mk_out(KIND_CHAR, KC_UP, c, MOD_NONE);
                    end
                end
            end
            PH_ESC: begin
                if (is_end || c == ESC_BYTE) begin
                    n_phase   = PH_IDLE;
                    res.valid = 1'b1;
                    res.item  = mk_out(KIND_CHAR, KC_UP, ESC_BYTE, MOD_NONE);
                end else if (c == "[") begin
                    n_phase = PH_CSI_FIRST;
                end else if (c == "O") begin
                    n_phase = PH_SS3_FIRST;
                end else begin
                    n_alt   = c;
                    n_phase = PH_ALT;
                end
            end
            PH_ALT: begin
                n_phase   = PH_IDLE;
                res.valid = 1'b1;
                if (is_end) begin
                    res.item = mk_out(KIND_CHAR, KC_UP, r_alt, MOD_ALT);
                end
            end
            PH_DRAIN: begin
                if (is_end) begin
                    n_phase   = PH_IDLE;
                    res.valid = 1'b1;
                end
            end
            default: begin
                // csi and ss3 parameter phases
                if (is_end) begin
                    n_phase   = PH_IDLE;
                    res.valid = 1'b1;
                    if (r_phase == PH_CSI_FIRST) begin
                        res.item = mk_out(KIND_CHAR, KC_UP, "[", MOD_ALT);
                    end else if (r_phase == PH_SS3_FIRST) begin
                        res.item = mk_out(KIND_CHAR, KC_UP, "O", MOD_ALT);
                    end
                end else if (r_phase == PH_CSI_FIRST && (c == "M" || c == "<")) begin
                    n_phase = PH_DRAIN;
                end else if (is_digit) begin
                    if (r_cnt == 2'd0 && r_fp < PARAM_CAP) begin
                        n_fp = fp_times10;
                    end else if (r_cnt == 2'd1 && r_sp < PARAM_CAP) begin
                        n_sp = sp_times10;
                    end
                    n_dseen = 1'b1;
                    n_phase = is_ss3 ? PH_SS3 : PH_CSI;
                end else if (c == ";") begin
                    if (!r_cnt[1]) begin
                        n_cnt = r_cnt + 2'd1;
                    end
                    n_dseen = 1'b0;
                    n_phase = is_ss3 ? PH_SS3 : PH_CSI;
                end else begin
                    // final byte
                    n_cnt     = cnt_f;
                    n_phase   = PH_IDLE;
                    res.valid = 1'b1;
                    if (is_ss3 && is_pqrs) begin
                        res.item = mk_out(KIND_KEY, fkey, 8'd0, mods);
                    end else if (is_ss3 && c == "M") begin
                        res.item = mk_out(KIND_KEY, KC_KPENT, 8'd0, mods);
                    end else if (is_ss3 && kp != 8'd0) begin
                        res.item = mk_out(KIND_CHAR, KC_UP, kp, mods);
                    end else if (!is_ss3 && c == "~") begin
                        if (tk[5]) begin
                            res.item = mk_out(KIND_KEY, tk[4:0], 8'd0, mods);
                        end
                    end else if (!is_ss3 && r_fp == 20'd1 && is_pqrs) begin
                        res.item = mk_out(KIND_KEY, fkey, 8'd0, mods);
                    end else if (lk[5]) begin
                        res.item = mk_out(KIND_KEY, lk[4:0], 8'd0, mods);
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_fp    <= 20'd0;
            r_sp    <= 20'd0;
            r_cnt   <= 2'd0;
            r_dseen <= 1'b0;
            r_alt   <= 8'd0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_fp    <= n_fp;
            r_sp    <= n_sp;
            r_cnt   <= n_cnt;
            r_dseen <= n_dseen;
            r_alt   <= n_alt;
        end
    end

    always_comb begin
        o_res       = res;
        o_res.valid = res.valid && i_fire;
    end

endmodule

`default_nettype wire

>>> design/tekd_out_stage.sv
// ----------------------------------------------------------------------------
// tekd_out_stage
// Result register: presents one result transaction until the sink takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module tekd_out_stage
    import tekd_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  t_res i_res,
    input  wire  i_stall,
    output logic o_free,
    output logic o_valid,
    output t_out o_data
);

    logic r_valid;
    t_out r_data;

    // room when empty or when the held result leaves this cycle
    assign o_free = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_res.valid) begin
            r_data <= i_res.item;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

>>> design/terminal_escape_key_decoder.sv
// ----------------------------------------------------------------------------
// terminal_escape_key_decoder
// Decodes terminal input bytes into keys, direct characters or not-a-key.
// ----------------------------------------------------------------------------
//  channel   direction   handshake                  payload
//  input     in          i_in_valid / o_in_stall    i_in_data  (t_in)
//  output    out         o_out_valid / i_out_stall  o_out_data (t_out)
//
//  one transaction per cycle sustained while the output does not stall; the path from
//  input to result is the input register, then decode into the result register
//  a transaction yields zero or one result; state advances only when decoded
//  synchronous active-low reset returns the parser to idle, both stages empty
//  an output stall holds the result and backs up into the input register
// ----------------------------------------------------------------------------
`default_nettype none

module terminal_escape_key_decoder
    import tekd_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_in_valid,
    input  t_in  i_in_data,
    output logic o_in_stall,
    output logic o_out_valid,
    input  wire  i_out_stall,
    output t_out o_out_data
);

    logic in_valid;
    t_in  in_data;
    logic out_free;
    logic fire;
    t_res res;

    assign fire = in_valid && out_free;

    tekd_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_data  (i_in_data),
        .o_stall (o_in_stall),
        .i_take  (out_free),
        .o_valid (in_valid),
        .o_data  (in_data)
    );

    tekd_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_item  (in_data),
        .o_res   (res)
    );

    tekd_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_res   (res),
        .i_stall (i_out_stall),
        .o_free  (out_free),
        .o_valid (o_out_valid),
        .o_data  (o_out_data)
    );

endmodule

`default_nettype wire

>>> design/tekd_checker.sv
// ----------------------------------------------------------------------------
// tekd_checker
// Port-level checks for the terminal escape key decoder.
// ----------------------------------------------------------------------------
`default_nettype none

module tekd_checker
    import tekd_pkg::*;
(
    input wire  i_clk,
    input wire  i_rst_n,
    input wire  i_in_valid,
    input t_in  i_in_data,
    input wire  i_in_stall,
    input wire  i_out_valid,
    input wire  i_out_stall,
    input t_out i_out_data
);

    // a stalled result transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_stall) |=> (i_out_valid && $stable(i_out_data)))
        else $error("result changed while stalled");

    // nothing is shown straight after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // fields not used by the kind read zero
    a_kind_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |->
            ((i_out_data.result_kind == KIND_NONE && i_out_data.key_code == 5'd0 &&
              i_out_data.char_code == 8'd0 && i_out_data.modifiers == MOD_NONE) ||
             (i_out_data.result_kind == KIND_CHAR && i_out_data.key_code == 5'd0) ||
             (i_out_data.result_kind == KIND_KEY && i_out_data.char_code == 8'd0 &&
              i_out_data.key_code <= KC_LAST)))
        else $error("result fields inconsistent with kind");

    // input only stalls behind a held result
    a_in_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_stall |-> (i_out_valid && i_out_stall))
        else $error("input stalled without output back-pressure");

    // a stalled input transaction holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_stall) |=> (i_in_valid && $stable(i_in_data)))
        else $error("input changed while stalled");

endmodule

bind terminal_escape_key_decoder tekd_checker u_tekd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_data   (i_in_data),
    .i_in_stall  (o_in_stall),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_out_data  (o_out_data)
);

`default_nettype wire
